/* src/efsp_pkg.sv */
`default_nettype none
package efsp_pkg;

	localparam int COUNT_WIDTH = 8;
	localparam int DIFF_LIMIT  = 100;
	localparam int DIFF_WIDTH  = 16;
	localparam int PEND_WIDTH  = 8;
	localparam int PULSE_MIN   = 3;
	localparam int PULSE_STEP  = 4;
	localparam int ADDR_WIDTH  = 4;

	// wide enough for count plus a full difference, and for the limit
	localparam int SUM_WIDTH = ((COUNT_WIDTH > DIFF_WIDTH) ? COUNT_WIDTH : DIFF_WIDTH) + 1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_PULSE  = 2'd1,
		OP_SLOW   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_FOLLOW   = 2'd0,
		REG_TO_START = 2'd1,
		REG_TO_END   = 2'd2,
		REG_UNUSED   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t                   op;
		logic                  up;
		logic [DIFF_WIDTH-1:0] diff;
		logic                  stop;
		logic                  end_free;
		logic                  start_free;
	} item_t;

	typedef struct packed {
		logic follow_enable;
		logic slow_to_start;
		logic slow_to_end;
	} cfg_t;

	typedef struct packed {
		logic                   moving_forward;
		logic [COUNT_WIDTH-1:0] fwd_count;
		logic [COUNT_WIDTH-1:0] bwd_count;
		logic                   high_phase_next;
		logic                   step_level;
		logic                   dir_level;
	} state_t;

	// low bits of a count, zero-filled when the count is narrower
	function automatic logic [PEND_WIDTH-1:0] pend_bits(input logic [COUNT_WIDTH-1:0] c);
		logic [COUNT_WIDTH+PEND_WIDTH-1:0] ext;
		ext = {{PEND_WIDTH{1'b0}}, c};
		return ext[PEND_WIDTH-1:0];
	endfunction

endpackage
`default_nettype wire

/* src/efsp_step.sv */
`default_nettype none
module efsp_step (
	input  efsp_pkg::item_t  item,
	input  efsp_pkg::cfg_t   cfg,
	input  efsp_pkg::state_t cur,
	output efsp_pkg::state_t nxt
);
	import efsp_pkg::*;

	localparam logic [SUM_WIDTH-1:0]   COUNT_MAX_W  = SUM_WIDTH'((1 << COUNT_WIDTH) - 1);
	localparam logic [SUM_WIDTH-1:0]   DIFF_LIMIT_W = SUM_WIDTH'(DIFF_LIMIT);
	localparam logic [COUNT_WIDTH-1:0] PULSE_MIN_W  = COUNT_WIDTH'(PULSE_MIN);
	localparam logic [COUNT_WIDTH-1:0] PULSE_STEP_W = COUNT_WIDTH'(PULSE_STEP);

	logic [SUM_WIDTH-1:0]   diff_w;
	logic [SUM_WIDTH-1:0]   sum;
	logic [COUNT_WIDTH-1:0] sat;
	logic [COUNT_WIDTH-1:0] act_count;
	logic                   halt;
	logic                   take;

	always_comb begin
		diff_w    = SUM_WIDTH'(item.diff);
		sum       = SUM_WIDTH'(item.up ? cur.fwd_count : cur.bwd_count) + diff_w;
		sat       = (sum > COUNT_MAX_W) ? COUNT_MAX_W[COUNT_WIDTH-1:0] : sum[COUNT_WIDTH-1:0];
		take      = cfg.follow_enable && (diff_w < DIFF_LIMIT_W);
		act_count = cur.moving_forward ? cur.fwd_count : cur.bwd_count;
		halt      = item.stop || (cur.moving_forward ? !item.end_free : !item.start_free);

		nxt = cur;
		unique case (item.op)
			OP_SAMPLE: begin
				if (take) begin
					nxt.moving_forward = item.up;
					nxt.dir_level      = !item.up;
					if (item.up) nxt.fwd_count = sat;
					else         nxt.bwd_count = sat;
				end
			end
			OP_PULSE: begin
				if (halt) begin
					act_count = '0;
				end else if (act_count > PULSE_MIN_W) begin
					if (cur.high_phase_next) begin
						nxt.step_level      = 1'b1;
						nxt.high_phase_next = 1'b0;
					end else begin
						nxt.step_level      = 1'b0;
						act_count           = act_count - PULSE_STEP_W;
						nxt.high_phase_next = 1'b1;
					end
				end
				if (cur.moving_forward) nxt.fwd_count = act_count;
				else                    nxt.bwd_count = act_count;
			end
			OP_SLOW: begin
				// both slow modes set: the tick changes nothing
				if (!(cfg.slow_to_start && cfg.slow_to_end)) begin
					if (cfg.slow_to_end && item.end_free) begin
						nxt.step_level = !cur.step_level;
						nxt.dir_level  = 1'b0;
					end
					if (cfg.slow_to_start && item.start_free) begin
						nxt.step_level = !cur.step_level;
						nxt.dir_level  = 1'b1;
					end
				end
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/encoder_following_step_pulser_top.sv */
// Encoder-following step pulser.
//
// Sample channel: sample_valid / sample_stall with the fields operation,
// encoder_up, encoder_diff, stop_request, end_switch_free, start_switch_free.
// An item is taken on a rising edge with sample_valid high and sample_stall low.
// Result channel: result_valid / result_stall carrying step_pin, dir_pin,
// forward_pending and backward_pending; every item gives exactly one result.
// A taken item sits in the input register while the state update feeds its result
// into the result register, which then presents it.
// Throughput: one item per cycle while the receiver does not stall; the figure is set
// by the state update, which reads and writes the direction, pending counts and step phase.
// When the receiver stalls the result holds and one further item can wait in
// the input register; sample_stall then rises until the result is taken.
// Configuration over APB: follow_enable at 0x0, slow_to_start at 0x4,
// slow_to_end at 0x8, bit 0 of the data; pready is always high.
// Reset (arst_n low) clears the registers, counts, levels and both channels.
`default_nettype none
module encoder_following_step_pulser_top (
	input  wire                              clk,
	input  wire                              arst_n,
	// APB configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [efsp_pkg::ADDR_WIDTH-1:0]  paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// sample channel
	input  wire                              sample_valid,
	output logic                             sample_stall,
	input  wire  [1:0]                       operation,
	input  wire                              encoder_up,
	input  wire  [efsp_pkg::DIFF_WIDTH-1:0]  encoder_diff,
	input  wire                              stop_request,
	input  wire                              end_switch_free,
	input  wire                              start_switch_free,
	// result channel
	output logic                             result_valid,
	input  wire                              result_stall,
	output logic                             step_pin,
	output logic                             dir_pin,
	output logic [efsp_pkg::PEND_WIDTH-1:0]  forward_pending,
	output logic [efsp_pkg::PEND_WIDTH-1:0]  backward_pending
);
	import efsp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;

	item_t    item_s1;
	logic     valid_s1;
	state_t   state_q;
	state_t   state_nxt;
	logic     advance;
	logic     sample_take;

	// ---- configuration ----
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FOLLOW:   cfg_q.follow_enable <= pwdata[0];
				REG_TO_START: cfg_q.slow_to_start <= pwdata[0];
				REG_TO_END:   cfg_q.slow_to_end   <= pwdata[0];
				REG_UNUSED:   ;
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_FOLLOW:   prdata[0] = cfg_q.follow_enable;
			REG_TO_START: prdata[0] = cfg_q.slow_to_start;
			REG_TO_END:   prdata[0] = cfg_q.slow_to_end;
			REG_UNUSED:   prdata    = '0;
			default:      prdata    = '0;
		endcase
	end

	// ---- handshake ----
	// stage 1 moves on whenever the result register is empty or being taken
	assign advance      = !result_valid || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign sample_take  = sample_valid && !sample_stall;

	// input register: payload unreset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_take) begin
			item_s1.op         <= op_t'(operation);
			item_s1.up         <= encoder_up;
			item_s1.diff       <= encoder_diff;
			item_s1.stop       <= stop_request;
			item_s1.end_free   <= end_switch_free;
			item_s1.start_free <= start_switch_free;
		end
	end

	efsp_step u_step (
		.item (item_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt)
	);

	// state update happens as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			step_pin         <= state_nxt.step_level;
			dir_pin          <= state_nxt.dir_level;
			forward_pending  <= pend_bits(state_nxt.fwd_count);
			backward_pending <= pend_bits(state_nxt.bwd_count);
		end
	end

endmodule
`default_nettype wire

/* src/efsp_checker.sv */
`default_nettype none
module efsp_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             sample_valid,
	input wire                             sample_stall,
	input wire                             result_valid,
	input wire                             result_stall,
	input wire                             step_pin,
	input wire                             dir_pin,
	input wire [efsp_pkg::PEND_WIDTH-1:0]  forward_pending,
	input wire [efsp_pkg::PEND_WIDTH-1:0]  backward_pending
);
	import efsp_pkg::*;

	// a taken item shows up as a result after the input register, or an older one is held
	a_item_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> ##1 result_valid)
		else $error("taken item produced no result");

	// with the result register empty there is no reason to stall the sender
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("sample stalled with result register empty");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> result_valid)
		else $error("stalled result dropped");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
		($stable(step_pin) && $stable(dir_pin) &&
		 $stable(forward_pending) && $stable(backward_pending)))
		else $error("stalled result payload changed");

endmodule

bind encoder_following_step_pulser_top efsp_checker u_efsp_checker (.*);
`default_nettype wire

/* tb/sv/encoder_following_step_pulser_top_test.sv */
module encoder_following_step_pulser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import efsp_pkg::*;

	// top of a pending count, the value a saturating add clamps to
	localparam int unsigned CNT_TOP = (32'd1 << COUNT_WIDTH) - 32'd1;
	// cycles with nothing moving on any port before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// a little margin after the last result
	localparam int TAIL_CYCLES = 4;

	// one result item as seen on the result channel
	typedef struct packed {
		logic                  step;
		logic                  dir;
		logic [PEND_WIDTH-1:0] fwd;
		logic [PEND_WIDTH-1:0] bwd;
	} pins_t;

	// a line of the directed table: either a register write or an input item,
	// the latter with an optional hand-worked result
	typedef struct {
		bit       is_cfg;
		reg_idx_t target;
		bit       val;
		item_t    item;
		bit       typed;
		pins_t    want;
	} row_t;

	logic                  clk;
	logic                  arst_n            = 1'b0;
	logic                  psel              = 1'b0;
	logic                  penable           = 1'b0;
	logic                  pwrite            = 1'b0;
	logic [ADDR_WIDTH-1:0] paddr             = '0;
	logic [31:0]           pwdata            = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  sample_valid      = 1'b0;
	logic                  sample_stall;
	logic [1:0]            operation         = '0;
	logic                  encoder_up        = 1'b0;
	logic [DIFF_WIDTH-1:0] encoder_diff      = '0;
	logic                  stop_request      = 1'b0;
	logic                  end_switch_free   = 1'b1;
	logic                  start_switch_free = 1'b1;
	logic                  result_valid;
	logic                  result_stall      = 1'b0;
	logic                  step_pin;
	logic                  dir_pin;
	logic [PEND_WIDTH-1:0] forward_pending;
	logic [PEND_WIDTH-1:0] backward_pending;

	// idling percentages for the sender and the receiver, changed per phase
	int unsigned send_gap_pct   = 25;
	int unsigned recv_stall_pct = 68;

	// shadow of the block: configuration and pulser state
	logic                   fol_en     = 1'b0;
	logic                   to_start   = 1'b0;
	logic                   to_end     = 1'b0;
	logic                   fwd_motion = 1'b0;
	logic                   phase_high = 1'b0;
	logic                   step_lvl   = 1'b0;
	logic                   dir_lvl    = 1'b0;
	logic [COUNT_WIDTH-1:0] fwd_cnt    = '0;
	logic [COUNT_WIDTH-1:0] bwd_cnt    = '0;

	// pin levels still owed by the block, oldest first
	pins_t due_pins[$];

	int mismatches  = 0;
	int results_seen = 0;
	int quiet_cycles = 0;

	row_t drill[$];

	encoder_following_step_pulser_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.operation         (operation),
		.encoder_up        (encoder_up),
		.encoder_diff      (encoder_diff),
		.stop_request      (stop_request),
		.end_switch_free   (end_switch_free),
		.start_switch_free (start_switch_free),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.step_pin          (step_pin),
		.dir_pin           (dir_pin),
		.forward_pending   (forward_pending),
		.backward_pending  (backward_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// pending count plus an encoder change, pinned at the count's top value
	function automatic logic [COUNT_WIDTH-1:0] add_clamped(logic [COUNT_WIDTH-1:0] c,
			logic [DIFF_WIDTH-1:0] d);
		int unsigned s;
		s = 32'(c) + 32'(d);
		if (s > CNT_TOP)
			s = CNT_TOP;
		return s[COUNT_WIDTH-1:0];
	endfunction

	// low bits of a count as they appear on the pending outputs
	function automatic logic [PEND_WIDTH-1:0] pend_of(logic [COUNT_WIDTH-1:0] c);
		int unsigned v;
		v = 32'(c);
		return v[PEND_WIDTH-1:0];
	endfunction

	// Moves the shadow state on by one accepted item and returns the pin
	// levels and pending counts the block should report for it.
	function automatic pins_t advance_pulser(item_t it);
		logic [COUNT_WIDTH-1:0] cnt;
		bit                     halt;
		pins_t                  p;
		case (it.op)
			OP_SAMPLE: begin
				// rejected samples (following off, or a jump too big) leave all alone
				if (fol_en && it.diff < DIFF_LIMIT) begin
					fwd_motion = it.up;
					dir_lvl    = !it.up;
					if (it.up)
						fwd_cnt = add_clamped(fwd_cnt, it.diff);
					else
						bwd_cnt = add_clamped(bwd_cnt, it.diff);
				end
			end
			OP_PULSE: begin
				// only the count of the current travel direction is worked on
				cnt  = fwd_motion ? fwd_cnt : bwd_cnt;
				halt = it.stop || (fwd_motion ? !it.end_free : !it.start_free);
				if (halt) begin
					cnt = '0;
				end else if (cnt > PULSE_MIN) begin
					if (phase_high) begin
						step_lvl   = 1'b1;
						phase_high = 1'b0;
					end else begin
						step_lvl   = 1'b0;
						cnt        = cnt - COUNT_WIDTH'(PULSE_STEP);
						phase_high = 1'b1;
					end
				end
				if (fwd_motion)
					fwd_cnt = cnt;
				else
					bwd_cnt = cnt;
			end
			OP_SLOW: begin
				// with both slow modes set the tick changes nothing
				if (!(to_start && to_end)) begin
					if (to_end && it.end_free) begin
						step_lvl = !step_lvl;
						dir_lvl  = 1'b0;
					end
					if (to_start && it.start_free) begin
						step_lvl = !step_lvl;
						dir_lvl  = 1'b1;
					end
				end
			end
			default: ;
		endcase
		p.step = step_lvl;
		p.dir  = dir_lvl;
		p.fwd  = pend_of(fwd_cnt);
		p.bwd  = pend_of(bwd_cnt);
		return p;
	endfunction

	function automatic row_t step_row(op_t op, bit up, int unsigned diff, bit stop, bit endf,
			bit startf);
		row_t r;
		r.is_cfg               = 1'b0;
		r.target               = REG_UNUSED;
		r.val                  = 1'b0;
		r.item.op              = op;
		r.item.up              = up;
		r.item.diff            = diff[DIFF_WIDTH-1:0];
		r.item.stop            = stop;
		r.item.end_free        = endf;
		r.item.start_free      = startf;
		r.typed                = 1'b0;
		r.want                 = '0;
		return r;
	endfunction

	// attach a hand-worked result to an item row
	function automatic row_t with_want(row_t r, bit s, bit d, int unsigned f, int unsigned b);
		r.typed     = 1'b1;
		r.want.step = s;
		r.want.dir  = d;
		r.want.fwd  = f[PEND_WIDTH-1:0];
		r.want.bwd  = b[PEND_WIDTH-1:0];
		return r;
	endfunction

	function automatic row_t cfg_row(reg_idx_t target, bit val);
		row_t r;
		r.is_cfg = 1'b1;
		r.target = target;
		r.val    = val;
		r.item   = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		return r;
	endfunction

	// Mostly well-formed traffic: samples inside the accepted range, pulse
	// ticks with free switches. A share of oversized jumps, stop requests,
	// reached limits and unused codes is mixed in.
	function automatic item_t random_item();
		item_t       it;
		int unsigned pick;
		int unsigned d;
		pick  = $urandom_range(99);
		it.op = pick < 35 ? OP_SAMPLE : pick < 75 ? OP_PULSE : pick < 90 ? OP_SLOW : OP_NONE;
		it.up = 1'($urandom_range(1));
		pick  = $urandom_range(9);
		if (pick < 7)
			d = $urandom_range(DIFF_LIMIT - 1);
		else if (pick == 7)
			d = DIFF_LIMIT - 1 + $urandom_range(1);
		else
			d = $urandom_range(65535);
		it.diff       = d[DIFF_WIDTH-1:0];
		it.stop       = ($urandom_range(9) == 0);
		it.end_free   = ($urandom_range(99) < 85);
		it.start_free = ($urandom_range(99) < 85);
		return it;
	endfunction

	// Offer one item, with random gaps beforehand, and hold it until taken.
	// Entered and left on a rising edge; valid is only lowered in a gap.
	task automatic push_sample(item_t it, bit typed, pins_t want);
		pins_t model;
		while ($urandom_range(99) < send_gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid      <= 1'b1;
		operation         <= it.op;
		encoder_up        <= it.up;
		encoder_diff      <= it.diff;
		stop_request      <= it.stop;
		end_switch_free   <= it.end_free;
		start_switch_free <= it.start_free;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		// taken at this edge: the shadow always advances, even for typed rows
		model = advance_pulser(it);
		due_pins.push_back(typed ? want : model);
	endtask

	// stop offering items and wait for every owed result
	task automatic drain();
		sample_valid <= 1'b0;
		while (due_pins.size() != 0)
			@(posedge clk);
	endtask

	// APB write: setup, then access until pready, then bus idle
	task automatic write_reg(reg_idx_t target, bit val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_WIDTH'({target, 2'b00});
		pwdata  <= {31'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (target)
			REG_FOLLOW:   fol_en   = val;
			REG_TO_START: to_start = val;
			REG_TO_END:   to_end   = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// receiver: stalls at random at the current rate
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < recv_stall_pct);

	// Result checker and hang watchdog. Values are read as they stood just
	// before the edge, so the edge ordering of the processes does not matter.
	always @(posedge clk) begin : check_results
		pins_t got;
		pins_t exp_p;
		if (arst_n && result_valid && !result_stall) begin
			got.step = step_pin;
			got.dir  = dir_pin;
			got.fwd  = forward_pending;
			got.bwd  = backward_pending;
			if (due_pins.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with nothing outstanding", results_seen);
			end else begin
				exp_p = due_pins.pop_front();
				if (got.step !== exp_p.step || got.dir !== exp_p.dir ||
						got.fwd !== exp_p.fwd || got.bwd !== exp_p.bwd) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d mismatch (exp/got): step %b/%b dir %b/%b fwd %0d/%0d bwd %0d/%0d",
							results_seen, exp_p.step, got.step, exp_p.dir, got.dir,
							exp_p.fwd, got.fwd, exp_p.bwd, got.bwd);
				end
			end
			results_seen++;
		end
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int combo;

		// Directed table. Rows with a hand-worked result run from reset to the
		// saturation check; the other rows lean on the shadow model.
		// nothing configured yet: unused code, sample with following off,
		// pulse with nothing pending, slow tick with no slow mode
		drill.push_back(with_want(step_row(OP_NONE, 1, 65535, 1, 0, 0), 0, 0, 0, 0));
		drill.push_back(with_want(step_row(OP_SAMPLE, 1, 5, 0, 1, 1), 0, 0, 0, 0));
		drill.push_back(with_want(step_row(OP_PULSE, 0, 0, 0, 1, 1), 0, 0, 0, 0));
		drill.push_back(with_want(step_row(OP_SLOW, 0, 0, 0, 1, 1), 0, 0, 0, 0));
		drill.push_back(cfg_row(REG_FOLLOW, 1'b1));
		// largest accepted change, then one at the limit and the widest: both dropped
		drill.push_back(with_want(step_row(OP_SAMPLE, 1, DIFF_LIMIT - 1, 0, 1, 1), 0, 0, 99, 0));
		drill.push_back(with_want(step_row(OP_SAMPLE, 1, DIFF_LIMIT, 0, 1, 1), 0, 0, 99, 0));
		drill.push_back(with_want(step_row(OP_SAMPLE, 0, 65535, 0, 1, 1), 0, 0, 99, 0));
		// forward count runs into saturation
		drill.push_back(step_row(OP_SAMPLE, 1, DIFF_LIMIT - 1, 0, 1, 1));
		drill.push_back(with_want(step_row(OP_SAMPLE, 1, DIFF_LIMIT - 1, 0, 1, 1), 0, 0, 255, 0));
		// low, high, low phases
		drill.push_back(step_row(OP_PULSE, 0, 0, 0, 1, 1));
		drill.push_back(step_row(OP_PULSE, 0, 0, 0, 1, 1));
		drill.push_back(step_row(OP_PULSE, 0, 0, 0, 1, 1));
		// backward with exactly three pending: no pulse; then four
		drill.push_back(step_row(OP_SAMPLE, 0, 3, 0, 1, 1));
		drill.push_back(step_row(OP_PULSE, 1, 0, 0, 1, 1));
		drill.push_back(step_row(OP_SAMPLE, 0, 1, 0, 1, 1));
		drill.push_back(step_row(OP_PULSE, 0, 0, 0, 1, 1));
		drill.push_back(step_row(OP_PULSE, 0, 0, 0, 1, 1));
		// start limit reached while going backward clears the count
		drill.push_back(step_row(OP_SAMPLE, 0, 60, 0, 1, 1));
		drill.push_back(step_row(OP_PULSE, 0, 0, 0, 1, 0));
		// stop request, then end limit reached, while going forward
		drill.push_back(step_row(OP_SAMPLE, 1, 8, 0, 1, 1));
		drill.push_back(step_row(OP_PULSE, 0, 0, 1, 1, 1));
		drill.push_back(step_row(OP_SAMPLE, 1, 40, 0, 1, 1));
		drill.push_back(step_row(OP_PULSE, 0, 0, 0, 0, 1));
		// slow run toward the end, both slow modes, then toward the start
		drill.push_back(cfg_row(REG_TO_END, 1'b1));
		drill.push_back(step_row(OP_SLOW, 0, 0, 0, 1, 1));
		drill.push_back(cfg_row(REG_TO_START, 1'b1));
		drill.push_back(step_row(OP_SLOW, 0, 0, 0, 1, 1));
		drill.push_back(cfg_row(REG_TO_END, 1'b0));
		drill.push_back(step_row(OP_SLOW, 0, 0, 0, 1, 1));
		drill.push_back(step_row(OP_SLOW, 0, 0, 0, 1, 0));

		// reset once, released on an edge
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (drill[i]) begin
			if (drill[i].is_cfg) begin
				drain();
				write_reg(drill[i].target, drill[i].val);
			end else begin
				push_sample(drill[i].item, drill[i].typed, drill[i].want);
			end
		end

		// Random phases: sender-light/receiver-heavy idling, then the reverse,
		// then none. Each phase rewrites all registers; the slow modes walk
		// through all four combinations and following is switched off now and then.
		for (int ph = 0; ph < 9; ph++) begin
			combo          = ph % 4;
			send_gap_pct   = ph < 3 ? 25 : ph < 6 ? 68 : 0;
			recv_stall_pct = ph < 3 ? 68 : ph < 6 ? 25 : 0;
			drain();
			write_reg(REG_FOLLOW, (ph % 3) != 1);
			write_reg(REG_TO_START, combo[0]);
			write_reg(REG_TO_END, combo[1]);
			repeat (100)
				push_sample(random_item(), 1'b0, '0);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* sim.f */
src/efsp_pkg.sv
src/efsp_step.sv
src/encoder_following_step_pulser_top.sv
src/efsp_checker.sv
tb/sv/encoder_following_step_pulser_top_test.sv
